### hw/rtl/mfdr_pkg.sv
// ----------------------------------------------------------------------------
// Mesh flood dedup relay package
// Item types, command and status groups, codes and constants shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package mfdr_pkg;

    localparam logic [7:0] ACK_TYPE    = 8'd75;
    localparam logic [8:0] JITTER_MIN  = 9'd100;
    localparam logic [8:0] JITTER_MAX  = 9'd500;
    localparam int         SLOT_IDX_W  = 3;

    typedef enum logic [1:0] {
        CMD_RX    = 2'd0,
        CMD_LOCAL = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd_code;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_ACK    = 3'd1,
        ACT_DUP    = 3'd2,
        ACT_ACCEPT = 3'd3,
        ACT_FIRE   = 3'd4,
        ACT_LOCAL  = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        EM_NONE      = 3'd0,
        EM_ACK       = 3'd1,
        EM_DUP       = 3'd2,
        EM_ACCEPT    = 3'd3,
        EM_LOCAL     = 3'd4,
        EM_FIRE_MORE = 3'd5,
        EM_FIRE_LAST = 3'd6
    } t_emit_sel;

    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_DECODE    = 3'd1,
        S_SCAN      = 3'd2,
        S_SCAN_TAIL = 3'd3,
        S_DECIDE    = 3'd4,
        S_SIMPLE    = 3'd5,
        S_TICK      = 3'd6,
        S_TICK_END  = 3'd7
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  frame_type;
        logic [31:0] message_id;
        logic [7:0]  hop_count;
        logic [31:0] now_ms;
        logic [8:0]  jitter_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] out_id;
        logic [7:0]  out_hops;
        logic [7:0]  out_type;
        logic        send_ack;
        logic        relay_booked;
        logic [2:0]  slot_index;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic      capture;
        logic      scan_start;
        logic      scan_step;
        logic      record;
        logic      book;
        logic      slot_start;
        logic      slot_step;
        logic      fire;
        logic      emit;
        t_emit_sel emit_sel;
    } t_ctrl_cmd;

    typedef struct packed {
        t_cmd_code cmd;
        logic      ack_type;
        logic      id_nonzero;
        logic      scan_last;
        logic      hit;
        logic      slot_last;
        logic      due;
        logic      pend_valid;
        logic      out_free;
    } t_dp_stat;

endpackage

### hw/rtl/mfdr_ctrl.sv
// ----------------------------------------------------------------------------
// Mesh flood dedup relay controller
// Sequences capture, the seen id scan, booking, local records and the relay
// slot sweep, and paces result loads against the output register.
// ----------------------------------------------------------------------------
module mfdr_ctrl
    import mfdr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    CMD_RX: begin
                        if (i_stat.ack_type) begin
                            n_state = S_SIMPLE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    CMD_TICK: begin
                        o_cmd.slot_start = 1'b1;
                        n_state          = S_TICK;
                    end
                    default: begin
                        n_state = S_SIMPLE;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_SCAN_TAIL;
                end
            end
            S_SCAN_TAIL: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.hit) begin
                        o_cmd.emit_sel = EM_DUP;
                    end else begin
                        o_cmd.record   = 1'b1;
                        o_cmd.book     = 1'b1;
                        o_cmd.emit_sel = EM_ACCEPT;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SIMPLE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.cmd == CMD_LOCAL) begin
                        o_cmd.record   = 1'b1;
                        o_cmd.emit_sel = EM_LOCAL;
                    end else if (i_stat.cmd == CMD_RX && i_stat.ack_type &&
                                 i_stat.id_nonzero) begin
                        o_cmd.emit_sel = EM_ACK;
                    end else begin
                        o_cmd.emit_sel = EM_NONE;
                    end
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                if (!(i_stat.due && i_stat.pend_valid && !i_stat.out_free)) begin
                    o_cmd.slot_step = 1'b1;
                    if (i_stat.due) begin
                        o_cmd.fire = 1'b1;
                        if (i_stat.pend_valid) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_sel = EM_FIRE_MORE;
                        end
                    end
                    if (i_stat.slot_last) begin
                        n_state = S_TICK_END;
                    end
                end
            end
            S_TICK_END: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = i_stat.pend_valid ? EM_FIRE_LAST : EM_NONE;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/mfdr_dpath.sv
// ----------------------------------------------------------------------------
// Mesh flood dedup relay datapath
// Holds the captured item, the seen id ring with its scan pipeline, the relay
// slots, the pending fired relay and the output register.
// ----------------------------------------------------------------------------
module mfdr_dpath
    import mfdr_pkg::*;
#(
    parameter int SEEN_DEPTH  = 32,
    parameter int RELAY_SLOTS = 5
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_ctrl_cmd i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(SEEN_DEPTH);
    localparam int SW = (RELAY_SLOTS > 1) ? $clog2(RELAY_SLOTS) : 1;
    localparam logic [AW-1:0] SEEN_LAST = AW'(SEEN_DEPTH - 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(RELAY_SLOTS - 1);

    t_in_item         r_item;

    logic [31:0]      r_seen_mem [SEEN_DEPTH];
    logic [SEEN_DEPTH-1:0] r_seen_vld;
    logic [AW-1:0]    r_seen_ptr;
    logic [AW-1:0]    r_scan_idx;
    logic [31:0]      r_rd_data;
    logic             r_rd_live;
    logic             r_cmp_en;
    logic             r_hit;

    logic [RELAY_SLOTS-1:0] r_slot_active;
    logic [31:0]      r_slot_fire [RELAY_SLOTS];
    logic [7:0]       r_slot_type [RELAY_SLOTS];
    logic [31:0]      r_slot_id   [RELAY_SLOTS];
    logic [7:0]       r_slot_ttl  [RELAY_SLOTS];
    logic [SW-1:0]    r_slot_idx;

    logic             r_pend_valid;
    logic [31:0]      r_pend_id;
    logic [7:0]       r_pend_ttl;
    logic [7:0]       r_pend_type;
    logic [SW-1:0]    r_pend_slot;

    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic [8:0]       jit_sat;
    logic [31:0]      fire_time;
    logic             any_free;
    logic [SW-1:0]    first_free;
    logic             booked;
    logic             due;
    logic             out_free;
    logic [31:0]      cmp_word;

    always_comb begin
        if (r_item.jitter_ms < JITTER_MIN) begin
            jit_sat = JITTER_MIN;
        end else if (r_item.jitter_ms > JITTER_MAX) begin
            jit_sat = JITTER_MAX;
        end else begin
            jit_sat = r_item.jitter_ms;
        end
    end

    assign fire_time = r_item.now_ms + 32'(jit_sat);

    always_comb begin
        any_free   = 1'b0;
        first_free = '0;
        for (int i = RELAY_SLOTS - 1; i >= 0; i--) begin
            if (!r_slot_active[i]) begin
                any_free   = 1'b1;
                first_free = SW'(i);
            end
        end
    end

    assign booked   = (r_item.hop_count != 8'd0) && any_free;
    assign due      = r_slot_active[r_slot_idx] &&
                      (r_item.now_ms >= r_slot_fire[r_slot_idx]);
    assign out_free = !r_out_valid || i_out_ready;
    assign cmp_word = r_rd_live ? r_rd_data : 32'd0;

    always_comb begin
        o_stat.cmd        = t_cmd_code'(r_item.cmd);
        o_stat.ack_type   = (r_item.frame_type == ACK_TYPE);
        o_stat.id_nonzero = (r_item.message_id != 32'd0);
        o_stat.scan_last  = (r_scan_idx == SEEN_LAST);
        o_stat.hit        = r_hit;
        o_stat.slot_last  = (r_slot_idx == SLOT_LAST);
        o_stat.due        = due;
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = out_free;
    end

    always_comb begin
        n_out        = '0;
        n_out.last   = 1'b1;
        case (i_cmd.emit_sel)
            EM_ACK: begin
                n_out.action = ACT_ACK;
                n_out.out_id = r_item.message_id;
            end
            EM_DUP: begin
                n_out.action = ACT_DUP;
                n_out.out_id = r_item.message_id;
            end
            EM_ACCEPT: begin
                n_out.action       = ACT_ACCEPT;
                n_out.out_id       = r_item.message_id;
                n_out.out_hops     = r_item.hop_count;
                n_out.out_type     = r_item.frame_type;
                n_out.send_ack     = (r_item.message_id != 32'd0);
                n_out.relay_booked = booked;
                n_out.slot_index   = booked ? SLOT_IDX_W'(first_free) : '0;
            end
            EM_LOCAL: begin
                n_out.action = ACT_LOCAL;
                n_out.out_id = r_item.message_id;
            end
            EM_FIRE_MORE, EM_FIRE_LAST: begin
                n_out.action     = ACT_FIRE;
                n_out.out_id     = r_pend_id;
                n_out.out_hops   = r_pend_ttl;
                n_out.out_type   = r_pend_type;
                n_out.slot_index = SLOT_IDX_W'(r_pend_slot);
                n_out.last       = (i_cmd.emit_sel == EM_FIRE_LAST);
            end
            default: begin
                n_out.action = ACT_NONE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_vld    <= '0;
            r_seen_ptr    <= '0;
            r_cmp_en      <= 1'b0;
            r_slot_active <= '0;
            r_pend_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.scan_step;
            if (i_cmd.record) begin
                r_seen_vld[r_seen_ptr] <= 1'b1;
                r_seen_ptr <= (r_seen_ptr == SEEN_LAST) ? '0 : r_seen_ptr + 1'b1;
            end
            if (i_cmd.book && booked) begin
                r_slot_active[first_free] <= 1'b1;
            end
            if (i_cmd.fire) begin
                r_slot_active[r_slot_idx] <= 1'b0;
            end
            if (i_cmd.slot_start) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.fire) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.emit && i_cmd.emit_sel == EM_FIRE_LAST) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + 1'b1;
        end
        if (i_cmd.scan_step) begin
            r_rd_live <= r_seen_vld[r_scan_idx];
        end
        if (i_cmd.scan_start) begin
            r_hit <= 1'b0;
        end else if (r_cmp_en && cmp_word == r_item.message_id) begin
            r_hit <= 1'b1;
        end
        if (i_cmd.book && booked) begin
            r_slot_fire[first_free] <= fire_time;
            r_slot_type[first_free] <= r_item.frame_type;
            r_slot_id[first_free]   <= r_item.message_id;
            r_slot_ttl[first_free]  <= r_item.hop_count - 8'd1;
        end
        if (i_cmd.slot_start) begin
            r_slot_idx <= '0;
        end else if (i_cmd.slot_step) begin
            r_slot_idx <= r_slot_idx + 1'b1;
        end
        if (i_cmd.fire) begin
            r_pend_id   <= r_slot_id[r_slot_idx];
            r_pend_ttl  <= r_slot_ttl[r_slot_idx];
            r_pend_type <= r_slot_type[r_slot_idx];
            r_pend_slot <= r_slot_idx;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    // Seen id ring storage.
    always_ff @(posedge i_clk) begin
        if (i_cmd.record) begin
            r_seen_mem[r_seen_ptr] <= r_item.message_id;
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= r_seen_mem[r_scan_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result loaded while the output register is occupied");

    a_book_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.book && booked) |-> !r_slot_active[first_free])
        else $error("relay booked into an active slot");

    a_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fire |=> !r_slot_active[$past(r_slot_idx)])
        else $error("fired relay slot stays active");

endmodule

### hw/rtl/mesh_flood_dedup_relay_core.sv
// ----------------------------------------------------------------------------
// Mesh flood dedup relay core
// Header engine for a flooding mesh: duplicate suppression over a ring of
// seen ids, acknowledgement detection and timed relay slots.
//
// Items enter on i_in_valid / o_in_ready and results leave on o_out_valid /
// i_out_ready; each input item yields one result, or one per fired relay on
// a tick, with last set on the final one. One item is handled at a time.
// A received non-ack header waits on the scan of the seen ring through its
// single read port; ack, local send and no-op items skip the scan. A tick
// makes one slot compare per cycle, holding while a due slot finds the last
// fired relay still waiting for a free output register. The input is ready
// again in the cycle after the last result is loaded. A result waits in the
// output register while the receiver stalls; the next item is still
// accepted, and processing holds only when another result must be loaded.
// Reset empties the seen ring (all entries read as zero), frees every relay
// slot and drops any waiting result; no clearing pass.
// ----------------------------------------------------------------------------
module mesh_flood_dedup_relay_core
    import mfdr_pkg::*;
#(
    parameter int SEEN_DEPTH  = 32,
    parameter int RELAY_SLOTS = 5
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    mfdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mfdr_dpath #(
        .SEEN_DEPTH  (SEEN_DEPTH),
        .RELAY_SLOTS (RELAY_SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
